// ===== hdl/shannon_name_word_decoder_unit_macros.svh =====
// Assertion macros for the name word decoder.
// Included by the top level; no other dependencies.
`ifndef SHANNON_NAME_WORD_DECODER_UNIT_MACROS_SVH
`define SHANNON_NAME_WORD_DECODER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SNWD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("snwd assertion failed");
// next-cycle implication
`define SNWD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("snwd assertion failed");
`else
`define SNWD_ASSERT_NOW(label, clk, rst, ante, cons)
`define SNWD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/snwd_pkg.sv =====
// Shared types, constants and character ROM for the name word decoder.
// No dependencies.
package snwd_pkg;

   localparam int WordWidth = 32;
   localparam int MaskBits  = 3;
   localparam int CodeBits  = WordWidth - MaskBits;  // 29 code bits
   localparam int CharWidth = 7;
   localparam int IndexWidth = 6;                    // 48-entry ROM

   // Code-length selector (top two code bits)
   localparam logic [1:0] SelShort = 2'b10;  // 10 -> 5-bit code
   localparam logic [1:0] SelLong  = 2'b11;  // 11 -> 7-bit code

   typedef logic [CodeBits-1:0]  code_type;
   typedef logic [CharWidth-1:0] char_type;

   // One decoded letter
   typedef struct packed {
      char_type character;
      logic     last_letter;
   } letter_type;

   // Character ROM, ASCII codes
   function automatic char_type char_rom(input logic [IndexWidth-1:0] idx);
      char_type c;
      case (idx)
         6'd0:  c = 7'h20;  6'd1:  c = 7'h72;  6'd2:  c = 7'h74;  6'd3:  c = 7'h6f;
         6'd4:  c = 7'h65;  6'd5:  c = 7'h61;  6'd6:  c = 7'h6e;  6'd7:  c = 7'h69;
         6'd8:  c = 7'h73;  6'd9:  c = 7'h6d;  6'd10: c = 7'h63;  6'd11: c = 7'h79;
         6'd12: c = 7'h6c;  6'd13: c = 7'h67;  6'd14: c = 7'h66;  6'd15: c = 7'h77;
         6'd16: c = 7'h64;  6'd17: c = 7'h76;  6'd18: c = 7'h70;  6'd19: c = 7'h62;
         6'd20: c = 7'h68;  6'd21: c = 7'h78;  6'd22: c = 7'h75;  6'd23: c = 7'h71;
         6'd24: c = 7'h6b;  6'd25: c = 7'h7a;  6'd26: c = 7'h6a;  6'd27: c = 7'h33;
         6'd28: c = 7'h34;  6'd29: c = 7'h35;  6'd30: c = 7'h36;  6'd31: c = 7'h37;
         6'd32: c = 7'h38;  6'd33: c = 7'h39;  6'd34: c = 7'h31;  6'd35: c = 7'h2d;
         6'd36: c = 7'h30;  6'd37: c = 7'h2e;  6'd38: c = 7'h32;  6'd39: c = 7'h2f;
         6'd40: c = 7'h3b;  6'd41: c = 7'h3a;  6'd42: c = 7'h21;  6'd43: c = 7'h2b;
         6'd44: c = 7'h40;  6'd45: c = 7'h2a;  6'd46: c = 7'h2c;  6'd47: c = 7'h3f;
         default: c = 7'h20;
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/snwd_code_step.sv =====
// Shared code-step unit: peels the leading code off the remaining word,
// looks up its character and returns the shifted word. Uses snwd_pkg.
module snwd_code_step (
   input  snwd_pkg::code_type   word,
   output snwd_pkg::code_type   next_word,
   output snwd_pkg::letter_type letter
);
   import snwd_pkg::*;

   logic [1:0]            sel;
   logic [IndexWidth-1:0] idx;
   code_type              shifted;

   assign sel = word[CodeBits-1 -: 2];

   // Length select, ROM index and shift
   always_comb begin
      case (sel)
         SelShort: begin
            idx     = {3'b001, word[CodeBits-3 -: 3]};
            shifted = word << 5;
         end
         SelLong: begin
            idx     = 6'd16 + {1'b0, word[CodeBits-3 -: 5]};
            shifted = word << 7;
         end
         default: begin
            idx     = {2'b00, word[CodeBits-1 -: 4]};
            shifted = word << 4;
         end
      endcase
   end

   assign next_word          = shifted;
   assign letter.character   = char_rom(idx);
   assign letter.last_letter = (shifted == '0);

endmodule

// ===== hdl/shannon_name_word_decoder_unit.sv =====
// Top level of the name word decoder: request capture, letter sequencer
// and result register. Uses snwd_pkg, snwd_code_step and the macro header.
//
// A request carries one packed name word; its low three bits are ignored.
// The decoder emits one letter per cycle unless the result side stalls,
// most significant code first, and flags the final one with rsp_last_letter.
// A word of k letters (0 to 8) keeps req_stall high after it is taken
// until its last code is stripped; the pace is set by the single code-step
// unit. An all-zero word produces no results and does not raise req_stall.
// The next request may be taken while the last letter of the previous one
// still waits in the result register.
`include "shannon_name_word_decoder_unit_macros.svh"

module shannon_name_word_decoder_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [31:0]            req_code_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output snwd_pkg::char_type     rsp_character,
   output logic                   rsp_last_letter
);
   import snwd_pkg::*;

   code_type   word_ff, word_in;
   logic       rsp_valid_ff, rsp_valid_in;
   letter_type letter_ff, letter_in;
   code_type   step_word;
   letter_type step_letter;
   logic       req_take;
   logic       advance;
   logic       busy;

   // Shared code-step unit
   snwd_code_step u_step (
      .word      (word_ff),
      .next_word (step_word),
      .letter    (step_letter)
   );

   // Busy while code bits remain in the held word
   assign busy      = (word_ff != '0);
   assign req_stall = busy;
   assign req_take  = req_valid && !busy;
   assign advance   = !rsp_valid_ff || !rsp_stall;

   // Sequencer: load a word, then strip one code per free result slot
   always_comb begin
      word_in      = word_ff;
      rsp_valid_in = rsp_valid_ff;
      letter_in    = letter_ff;
      if (advance) begin
         rsp_valid_in = busy;
         if (busy) begin
            letter_in = step_letter;
            word_in   = step_word;
         end
      end
      if (req_take) begin
         word_in = req_code_word[WordWidth-1:MaskBits];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      letter_ff <= letter_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_character   = letter_ff.character;
   assign rsp_last_letter = letter_ff.last_letter;

   // Checks
   `SNWD_ASSERT_NEXT(a_load_nonzero, clock, reset, req_take && word_in != '0, busy)
   `SNWD_ASSERT_NEXT(a_last_empties, clock, reset, advance && busy && step_letter.last_letter, !busy)
   `SNWD_ASSERT_NOW(a_more_pending, clock, reset, rsp_valid_ff && !letter_ff.last_letter, busy)

endmodule

// ===== tb/shannon_name_word_decoder_unit_tb.sv =====
// Self-checking testbench for shannon_name_word_decoder_unit: decodes every
// accepted name word in a scoreboard and matches the letter stream in order.
// Depends on snwd_pkg and the decoder top level only.
`timescale 1ns / 1ps

module shannon_name_word_decoder_unit_tb;
   import snwd_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int HoldCycles = 300;
   localparam int DrainCycles = 20;
   localparam int MaxLetters = 8;

   // Letter table plus expected letter stream
   class name_decode_board;
      string letter_rom = " rtoeanismcylgfwdvpbhxuqkzj34567891-0.2/;:!+@*,?";
      letter_type pending[$];
      int errors;

      // decode one accepted word into its expected letters
      function void note_word(logic [31:0] word);
         logic [31:0] w;
         int idx;
         int len;
         int n;
         letter_type l;
         w = word & 32'hFFFF_FFF8;
         n = 0;
         while (w != 0 && n < MaxLetters) begin
            case (w[31:30])
               SelShort: begin
                  len = 5;
                  idx = int'(w[31:27]) - 8;
               end
               SelLong: begin
                  len = 7;
                  idx = int'(w[31:25]) - 80;
               end
               default: begin
                  len = 4;
                  idx = int'(w[31:28]);
               end
            endcase
            idx = idx % 48;
            w = w << len;
            l.character = char_type'(letter_rom[idx]);
            l.last_letter = (w == 0);
            pending.push_back(l);
            n++;
         end
      endfunction

      // compare one accepted letter with the oldest expectation
      function void check_letter(char_type ch, logic last);
         letter_type exp_l;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected letter: char=%h last=%b", ch, last);
            return;
         end
         exp_l = pending.pop_front();
         if (exp_l.character !== ch || exp_l.last_letter !== last) begin
            errors++;
            if (errors <= 10)
               $display("letter mismatch: expected char=%h last=%b, got char=%h last=%b",
                        exp_l.character, exp_l.last_letter, ch, last);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_code_word;
   logic        rsp_valid;
   logic        rsp_stall;
   char_type    rsp_character;
   logic        rsp_last_letter;

   bit idling_on;
   bit hold_request;
   name_decode_board board = new();

   shannon_name_word_decoder_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_code_word   (req_code_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_character   (rsp_character),
      .rsp_last_letter (rsp_last_letter)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Offer one request, with random idle cycles ahead of it
   task automatic send_word(input logic [31:0] word);
      while (idling_on && $urandom_range(0, 99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_code_word <= word;
      do @(posedge clock); while (req_stall);
      board.note_word(word);
   endtask

   // Drop valid and wait until every expected letter has arrived
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // Random requests: mostly well-formed code sequences, some raw noise
   task automatic run_random(input int count);
      logic [31:0] word;
      logic [31:0] code;
      int mode;
      int pos;
      int nletters;
      int idx;
      int len;
      for (int i = 0; i < count; i++) begin
         mode = $urandom_range(0, 9);
         if (mode < 6) begin
            word = 0;
            pos = 32;
            nletters = $urandom_range(1, MaxLetters);
            for (int k = 0; k < nletters; k++) begin
               idx = $urandom_range(0, 47);
               if (idx < 8) begin
                  len = 4;
                  code = idx;
               end else if (idx < 16) begin
                  len = 5;
                  code = idx + 8;
               end else begin
                  len = 7;
                  code = idx + 80;
               end
               if (len > pos - 3) break;
               pos -= len;
               word |= code << pos;
            end
            word |= $urandom_range(0, 7);
         end else if (mode < 8) begin
            word = $urandom();
         end else if (mode == 8) begin
            word = $urandom() >> $urandom_range(0, 31);
         end else begin
            word = $urandom_range(0, 7);
         end
         send_word(word);
      end
   endtask

   // Result side: check accepted letters, random stalls, one long hold-off
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            board.check_letter(rsp_character, rsp_last_letter);
         if (hold_request && hold_left == 0)
            hold_left = HoldCycles;
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
            if (hold_left == 0)
               hold_request = 1'b0;
         end else begin
            rsp_stall <= idling_on && ($urandom_range(0, 99) < 27);
         end
      end
   end

   // Watchdog
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("shannon_name_word_decoder_unit_tb NOT OK");
      $finish;
   end

   // Main sequence
   initial begin
      logic [31:0] directed_words[];
      directed_words = '{
         32'h0000_0000,   // empty
         32'h0000_0007,   // mask bits only, still empty
         32'hFFFF_FFFF,
         32'hFFFF_FFF8,
         32'h0000_0008,   // seven spaces then one trailing bit
         32'h1111_1118,   // eight letters
         32'h1000_0000,
         32'h8000_0000,   // first 5-bit code
         32'hB800_0000,   // last 5-bit code
         32'hC000_0000,   // first 7-bit code
         32'hFE00_0000,   // last 7-bit code
         32'h0F00_0000,   // space then long code
         32'h7000_0000,
         32'h8888_8888,
         32'hAAAA_AAAA,
         32'h5555_5555,
         32'h1234_5678,
         32'h0000_0010,
         32'hF0F0_F0F7
      };
      idling_on = 1'b1;
      hold_request = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_code_word <= 32'h0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_words[i])
         send_word(directed_words[i]);
      drain();

      run_random(200);

      // no idling on either side
      idling_on = 1'b0;
      run_random(80);
      idling_on = 1'b1;

      // receiver holds off while requests keep coming
      hold_request = 1'b1;
      run_random(40);
      drain();

      run_random(40);
      drain();
      repeat (DrainCycles) @(posedge clock);

      if (board.errors == 0 && board.pending.size() == 0)
         $display("shannon_name_word_decoder_unit_tb OK");
      else
         $display("shannon_name_word_decoder_unit_tb NOT OK");
      $finish;
   end

endmodule
